/* rtl/healpix_ring_nest_convert_top_macros.svh */
// Assertion helpers shared by the conversion pipeline.
`ifndef HEALPIX_RING_NEST_CONVERT_TOP_MACROS_SVH
`define HEALPIX_RING_NEST_CONVERT_TOP_MACROS_SVH

// Implication in the same cycle, checked outside reset.
`define HRNC_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Implication into the next cycle, checked outside reset.
`define HRNC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/hrnc_pkg.sv */
`timescale 1ns / 1ps
package hrnc_pkg;

   localparam int MAX_ORDER = 13;
   localparam int ORDER_W   = 4;
   localparam int PIX_W     = 30;
   localparam int COORD_W   = 13;
   localparam int ROOT_W    = 14;
   localparam int SQ_ARG_W  = 2 * ROOT_W;
   localparam int SQ_PER    = 2;
   localparam int SQ_STAGES = ROOT_W / SQ_PER;
   localparam int CSR_AW    = 3;

   localparam logic ACT_RING2NEST = 1'b0;
   localparam logic ACT_NEST2RING = 1'b1;

   localparam logic [CSR_AW-1:0] CSR_ADDR_ORDER = 3'd0;

   typedef enum logic [1:0] {
      REG_NORTH,
      REG_BELT,
      REG_SOUTH
   } region_type;

   typedef struct packed {
      logic             action;
      logic [PIX_W-1:0] pixel_index;
   } req_type;

   typedef struct packed {
      logic [PIX_W-1:0] converted_index;
      logic             index_error;
   } rsp_type;

   // Everything decided at entry that rides along the root extraction.
   typedef struct packed {
      logic               action;
      logic [PIX_W-1:0]   pixel_index;
      logic               err;
      region_type         region;
      logic [3:0]         nf;
      logic [COORD_W-1:0] ni;
      logic [COORD_W-1:0] nj;
      logic [15:0]        nring;
   } front_type;

   function automatic logic [2:0] face_phase(input logic [3:0] f);
      logic [2:0] r;
      case (f)
         4'd0:  r = 3'd1;
         4'd1:  r = 3'd3;
         4'd2:  r = 3'd5;
         4'd3:  r = 3'd7;
         4'd4:  r = 3'd0;
         4'd5:  r = 3'd2;
         4'd6:  r = 3'd4;
         4'd7:  r = 3'd6;
         4'd8:  r = 3'd1;
         4'd9:  r = 3'd3;
         4'd10: r = 3'd5;
         4'd11: r = 3'd7;
         default: r = 3'd0;
      endcase
      return r;
   endfunction

endpackage

/* rtl/hrnc_sqrt_pipe.sv */
`timescale 1ns / 1ps
module hrnc_sqrt_pipe
   import hrnc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  front_type           in_front,
   input  logic [SQ_ARG_W-1:0] in_arg,
   output logic                out_valid,
   input  logic                out_ready,
   output front_type           out_front,
   output logic [ROOT_W-1:0]   out_root
);

   typedef struct packed {
      logic [ROOT_W+2:0]   rem;
      logic [ROOT_W-1:0]   root;
      logic [SQ_ARG_W-1:0] x;
   } sq_type;

   // One digit of the restoring square root: two argument bits in, one root bit out.
   function automatic sq_type sq_iter(input sq_type s);
      sq_type     r;
      logic [ROOT_W+4:0] rem2;
      logic [ROOT_W+4:0] trial;
      rem2  = {s.rem, s.x[SQ_ARG_W-1 -: 2]};
      trial = {3'b000, s.root, 2'b01};
      r.x   = {s.x[SQ_ARG_W-3:0], 2'b00};
      if (rem2 >= trial) begin
         r.rem  = (ROOT_W+3)'(rem2 - trial);
         r.root = {s.root[ROOT_W-2:0], 1'b1};
      end else begin
         r.rem  = (ROOT_W+3)'(rem2);
         r.root = {s.root[ROOT_W-2:0], 1'b0};
      end
      return r;
   endfunction

   logic [SQ_STAGES-1:0] valid_ff;
   logic [SQ_STAGES-1:0] rdy;
   sq_type               st_ff [SQ_STAGES];
   front_type            fr_ff [SQ_STAGES];

   for (genvar s = 0; s < SQ_STAGES; s++) begin : g_stage
      logic      prev_valid;
      logic      next_ready;
      sq_type    prev_st;
      front_type prev_fr;
      sq_type    st_in;

      if (s == 0) begin : g_first
         assign prev_valid = in_valid;
         assign prev_st    = '{rem: '0, root: '0, x: in_arg};
         assign prev_fr    = in_front;
      end else begin : g_rest
         assign prev_valid = valid_ff[s-1];
         assign prev_st    = st_ff[s-1];
         assign prev_fr    = fr_ff[s-1];
      end

      if (s == SQ_STAGES - 1) begin : g_last
         assign next_ready = out_ready;
      end else begin : g_mid
         assign next_ready = rdy[s+1];
      end

      assign rdy[s] = !valid_ff[s] || next_ready;

      always_comb begin
         st_in = prev_st;
         for (int n = 0; n < SQ_PER; n++) begin
            st_in = sq_iter(st_in);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (rdy[s]) begin
            valid_ff[s] <= prev_valid;
         end
         if (rdy[s] && prev_valid) begin
            st_ff[s] <= st_in;
            fr_ff[s] <= prev_fr;
         end
      end
   end

   assign in_ready  = rdy[0];
   assign out_valid = valid_ff[SQ_STAGES-1];
   assign out_front = fr_ff[SQ_STAGES-1];
   assign out_root  = st_ff[SQ_STAGES-1].root;

endmodule

/* rtl/healpix_ring_nest_convert_top.sv */
`timescale 1ns / 1ps
// Channel   | Direction | Beat
// req_      | in        | action, pixel_index (req_type)
// rsp_      | out       | converted_index, index_error (rsp_type)
// csr_      | in/out    | APB-style write/read of the order register
//
// Each accepted beat passes the entry stage, the root extraction and the back stages, one beat per
// cycle while rsp_ready is high. The root extraction has seven stages of two root bits each.
// Reset clears all valid bits and sets the order to zero.
// Each stage holds its beat while the next stage is full and stalled, so a stall on rsp_ready
// backs up one stage at a time and bubbles are squeezed out.
module healpix_ring_nest_convert_top
   import hrnc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_type           rsp_data,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

`include "healpix_ring_nest_convert_top_macros.svh"

   typedef logic signed [31:0] sint_type;

   typedef struct packed {
      front_type          fr;
      logic [ROOT_W-1:0]  nr;
      logic [31:0]        prod;
      sint_type           phim1;
      sint_type           ring;
      logic [14:0]        nrs;
      logic               shift;
      sint_type           ea;
      sint_type           eb;
      sint_type           lpv;
      sint_type           base;
      logic [3:0]         face;
      logic [COORD_W-1:0] ci;
      logic [COORD_W-1:0] cj;
      logic [PIX_W-1:0]   res;
   } mid_type;

   function automatic logic [2*COORD_W-1:0] spread_bits(input logic [COORD_W-1:0] v);
      logic [2*COORD_W-1:0] r;
      r = '0;
      for (int b = 0; b < COORD_W; b++) begin
         r[2*b] = v[b];
      end
      return r;
   endfunction

   function automatic logic [COORD_W-1:0] gather_bits(input logic [2*COORD_W-1:0] v);
      logic [COORD_W-1:0] r;
      for (int b = 0; b < COORD_W; b++) begin
         r[b] = v[2*b];
      end
      return r;
   endfunction

   // ---------------- configuration ----------------
   logic [ORDER_W-1:0] order_ff;
   logic [ORDER_W-1:0] k;
   sint_type           ns, npix, ncap, mask2k;
   logic [COORD_W-1:0] cmask;

   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready
                   && csr_paddr == CSR_ADDR_ORDER) begin
         order_ff <= csr_pwdata[ORDER_W-1:0];
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == CSR_ADDR_ORDER) ? {28'd0, order_ff} : 32'd0;

   // Change the order only while the pipeline is empty (not enforced); every stage reads it live.
   assign k      = (order_ff > ORDER_W'(MAX_ORDER)) ? ORDER_W'(MAX_ORDER) : order_ff;
   assign ns     = 32'sd1 <<< k;
   assign npix   = 32'sd12 <<< {k, 1'b0};
   assign ncap   = (32'sd1 <<< ({k, 1'b0} + 5'd1)) - (32'sd1 <<< (k + 4'd1));
   assign mask2k = (32'sd1 <<< {k, 1'b0}) - 32'sd1;
   assign cmask  = COORD_W'(ns - 32'sd1);

   // ---------------- entry stage ----------------
   logic                v1_ff;
   logic                rdy1;
   front_type           f1_ff;
   logic [SQ_ARG_W-1:0] arg1_ff;
   front_type           f1_in;
   logic [SQ_ARG_W-1:0] arg1_in;
   logic                sq_in_ready;

   always_comb begin
      sint_type pix_s;
      sint_type low;
      sint_type nring;
      pix_s = $signed(32'(req_data.pixel_index));
      low   = pix_s & mask2k;
      f1_in.action      = req_data.action;
      f1_in.pixel_index = req_data.pixel_index;
      f1_in.err         = pix_s >= npix;
      f1_in.nf          = 4'(pix_s >>> {k, 1'b0});
      f1_in.ni          = gather_bits(low[2*COORD_W-1:0]);
      f1_in.nj          = gather_bits(low[2*COORD_W:1]);
      nring = ($signed(32'({2'b00, f1_in.nf[3:2]} + 4'd2)) <<< k)
            - $signed(32'(f1_in.ni)) - $signed(32'(f1_in.nj)) - 32'sd1;
      f1_in.nring = 16'(nring);
      arg1_in     = '0;
      if (req_data.action == ACT_RING2NEST) begin
         if (pix_s < ncap) begin
            f1_in.region = REG_NORTH;
            arg1_in      = SQ_ARG_W'((pix_s <<< 1) + 32'sd1);
         end else if (pix_s >= npix - ncap) begin
            f1_in.region = REG_SOUTH;
            arg1_in      = SQ_ARG_W'(((npix - pix_s) <<< 1) - 32'sd1);
         end else begin
            f1_in.region = REG_BELT;
         end
      end else begin
         if (nring < ns) begin
            f1_in.region = REG_NORTH;
         end else if (nring <= ns + (ns <<< 1)) begin
            f1_in.region = REG_BELT;
         end else begin
            f1_in.region = REG_SOUTH;
         end
      end
   end

   assign rdy1      = !v1_ff || sq_in_ready;
   assign req_ready = rdy1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (rdy1) begin
         v1_ff <= req_valid;
      end
      if (rdy1 && req_valid) begin
         f1_ff   <= f1_in;
         arg1_ff <= arg1_in;
      end
   end

   // ---------------- root extraction ----------------
   logic              sq_valid;
   logic              rdy9;
   front_type         sq_front;
   logic [ROOT_W-1:0] sq_root;

   hrnc_sqrt_pipe u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v1_ff),
      .in_ready  (sq_in_ready),
      .in_front  (f1_ff),
      .in_arg    (arg1_ff),
      .out_valid (sq_valid),
      .out_ready (rdy9),
      .out_front (sq_front),
      .out_root  (sq_root)
   );

   // ---------------- back stages ----------------
   logic    v9_ff, v10_ff, v11_ff, v12_ff, v13_ff;
   logic    rdy10, rdy11, rdy12, rdy13;
   mid_type m9_ff, m10_ff, m11_ff, m12_ff;
   mid_type m9_in, m10_in, m11_in, m12_in;
   rsp_type out_ff, out_in;

   assign rdy13 = !v13_ff || rsp_ready;
   assign rdy12 = !v12_ff || rdy13;
   assign rdy11 = !v11_ff || rdy12;
   assign rdy10 = !v10_ff || rdy11;
   assign rdy9  = !v9_ff || rdy10;

   // Ring number and the one product each direction needs.
   always_comb begin
      logic [15:0] opa, opb;
      logic [15:0] m;
      m9_in    = '0;
      m9_in.fr = sq_front;
      m9_in.nr = ROOT_W'((15'(sq_root) + 15'd1) >> 1);
      m        = 16'(ns <<< 2) - sq_front.nring;
      opa      = '0;
      opb      = '0;
      if (sq_front.action == ACT_RING2NEST) begin
         if (sq_front.region != REG_BELT) begin
            opa = 16'(m9_in.nr);
            opb = 16'(m9_in.nr) - 16'd1;
         end
      end else begin
         case (sq_front.region)
            REG_NORTH: begin
               opa = sq_front.nring;
               opb = sq_front.nring - 16'd1;
            end
            REG_SOUTH: begin
               opa = m;
               opb = m + 16'd1;
            end
            default: begin
               opa = '0;
               opb = '0;
            end
         endcase
      end
      m9_in.prod = opa * opb;
   end

   // Position within the ring, or the pieces of the local position.
   always_comb begin
      sint_type    r, prod2, nr_s, ip, tmp, ring_n, nrs_s;
      logic [17:0] fpn;
      m10_in = m9_ff;
      r      = $signed(32'(m9_ff.fr.pixel_index));
      prod2  = $signed(m9_ff.prod) <<< 1;
      nr_s   = $signed(32'(m9_ff.nr));
      ip     = r - ncap;
      tmp    = ip >>> (k + 4'd2);
      ring_n = $signed(32'(m9_ff.fr.nring));
      nrs_s  = '0;
      fpn    = '0;
      if (m9_ff.fr.action == ACT_RING2NEST) begin
         case (m9_ff.fr.region)
            REG_NORTH: begin
               m10_in.phim1 = r - prod2;
               m10_in.ring  = nr_s;
               m10_in.nrs   = 15'(m9_ff.nr);
               m10_in.shift = 1'b0;
            end
            REG_SOUTH: begin
               m10_in.phim1 = r + prod2 + (nr_s <<< 2) - npix;
               m10_in.ring  = (ns <<< 2) - nr_s;
               m10_in.nrs   = 15'(m9_ff.nr);
               m10_in.shift = 1'b0;
            end
            default: begin
               m10_in.phim1 = ip & ((ns <<< 2) - 32'sd1);
               m10_in.ring  = tmp + ns;
               m10_in.nrs   = 15'(ns);
               m10_in.shift = tmp[0];
               m10_in.ea    = m10_in.phim1 - ((32'sd1 + tmp) >>> 1);
               m10_in.eb    = m10_in.phim1 - ((32'sd1 - tmp + (ns <<< 1)) >>> 1);
            end
         endcase
      end else begin
         case (m9_ff.fr.region)
            REG_NORTH: begin
               nrs_s       = ring_n;
               m10_in.shift = 1'b0;
               m10_in.base = prod2;
            end
            REG_BELT: begin
               nrs_s        = ns;
               m10_in.shift = ring_n[0] ^ ns[0];
               m10_in.base  = ncap + ((ring_n - ns) <<< (k + 4'd2));
            end
            default: begin
               nrs_s        = (ns <<< 2) - ring_n;
               m10_in.shift = 1'b0;
               m10_in.base  = npix - prod2;
            end
         endcase
         fpn        = face_phase(m9_ff.fr.nf) * 15'(nrs_s);
         m10_in.lpv = $signed(32'(fpn)) + $signed(32'(m9_ff.fr.ni))
                    - $signed(32'(m9_ff.fr.nj)) + 32'sd1 + $signed(32'(m10_in.shift));
      end
   end

   // Base face, or the wrapped local position.
   always_comb begin
      sint_type   nrs_s, a2, ifm, ifp, q, lp;
      logic       t;
      logic [3:0] qd;
      m11_in = m10_ff;
      nrs_s  = $signed(32'(m10_ff.nrs));
      t      = m10_ff.phim1 >= (nrs_s <<< 1);
      a2     = t ? m10_ff.phim1 - (nrs_s <<< 1) : m10_ff.phim1;
      qd     = {2'b00, t, a2 >= nrs_s};
      ifm    = 32'sd1 + (m10_ff.ea >>> k);
      ifp    = 32'sd1 + (m10_ff.eb >>> k);
      // The division by two rounds toward zero, so negative odd values step up.
      q      = m10_ff.lpv >>> 1;
      if (m10_ff.lpv[31] && m10_ff.lpv[0]) begin
         q = q + 32'sd1;
      end
      lp = q - 32'sd1;
      if (lp < 0) begin
         lp = lp + (ns <<< 2);
      end else if (lp >= (ns <<< 2)) begin
         lp = lp - (ns <<< 2);
      end
      m11_in.lpv = lp;
      case (m10_ff.fr.region)
         REG_NORTH: m11_in.face = qd;
         REG_SOUTH: m11_in.face = qd + 4'd8;
         default: begin
            if (ifp == ifm) begin
               m11_in.face = 4'(ifp) | 4'd4;
            end else if (ifp < ifm) begin
               m11_in.face = 4'(ifp);
            end else begin
               m11_in.face = 4'(ifm + 32'sd8);
            end
         end
      endcase
   end

   // In-face coordinates, or the final ring index.
   always_comb begin
      sint_type    rr, p;
      logic [17:0] fpn;
      m12_in = m11_ff;
      fpn    = face_phase(m11_ff.face) * m11_ff.nrs;
      rr     = ($signed(32'({2'b00, m11_ff.face[3:2]} + 4'd2)) <<< k)
             - m11_ff.ring - 32'sd1;
      p      = (m11_ff.phim1 <<< 1) + 32'sd1 - $signed(32'(fpn))
             - $signed(32'(m11_ff.shift));
      if (p >= (ns <<< 1)) begin
         p = p - (ns <<< 3);
      end
      m12_in.ci  = COORD_W'((rr + p) >>> 1) & cmask;
      m12_in.cj  = COORD_W'((rr - p) >>> 1) & cmask;
      m12_in.res = PIX_W'(m11_ff.base + m11_ff.lpv);
   end

   // Interleave and pick the result.
   always_comb begin
      out_in.index_error = m12_ff.fr.err;
      if (m12_ff.fr.err) begin
         out_in.converted_index = '0;
      end else if (m12_ff.fr.action == ACT_RING2NEST) begin
         out_in.converted_index = (PIX_W'(m12_ff.face) << {k, 1'b0})
                                + PIX_W'(spread_bits(m12_ff.ci))
                                + PIX_W'({spread_bits(m12_ff.cj), 1'b0});
      end else begin
         out_in.converted_index = m12_ff.res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v9_ff  <= 1'b0;
         v10_ff <= 1'b0;
         v11_ff <= 1'b0;
         v12_ff <= 1'b0;
         v13_ff <= 1'b0;
      end else begin
         if (rdy9)  v9_ff  <= sq_valid;
         if (rdy10) v10_ff <= v9_ff;
         if (rdy11) v11_ff <= v10_ff;
         if (rdy12) v12_ff <= v11_ff;
         if (rdy13) v13_ff <= v12_ff;
      end
      if (rdy9 && sq_valid) m9_ff  <= m9_in;
      if (rdy10 && v9_ff)   m10_ff <= m10_in;
      if (rdy11 && v10_ff)  m11_ff <= m11_in;
      if (rdy12 && v11_ff)  m12_ff <= m12_in;
      if (rdy13 && v12_ff)  out_ff <= out_in;
   end

   assign rsp_valid = v13_ff;
   assign rsp_data  = out_ff;

   `HRNC_ASSERT_NOW(a_err_zero, rsp_valid && rsp_data.index_error, rsp_data.converted_index == '0, "flagged beat carries a nonzero index")
   `HRNC_ASSERT_NOW(a_in_range, rsp_valid && !rsp_data.index_error, $signed(32'(rsp_data.converted_index)) < npix, "converted index out of range")
   `HRNC_ASSERT_NEXT(a_entry_load, req_valid && req_ready, v1_ff, "accepted beat missing at entry stage")

endmodule

/* tb/healpix_ring_nest_convert_top_tb.sv */
`timescale 1ns / 1ps
module healpix_ring_nest_convert_top_tb;
   import hrnc_pkg::*;

   // Column phase of each base face in units of the ring length.
   localparam longint FACE_COL [16] = '{1, 3, 5, 7, 0, 2, 4, 6, 1, 3, 5, 7, 0, 0, 0, 0};

   function automatic longint spread_coord(longint v);
      longint o;
      o = 0;
      for (int b = 0; b < 16; b++) o[2*b] = v[b];
      return o;
   endfunction

   function automatic longint gather_coord(longint v);
      longint o;
      o = 0;
      for (int b = 0; b < 16; b++) o[b] = v[2*b];
      return o;
   endfunction

   function automatic longint root_floor(longint v);
      longint x, res, bt;
      x = (v > 0) ? v : 0;
      res = 0;
      bt = longint'(1) << 32;
      while (bt > x) bt = bt >> 2;
      while (bt != 0) begin
         if (x >= res + bt) begin
            x = x - (res + bt);
            res = (res >> 1) + bt;
         end else begin
            res = res >> 1;
         end
         bt = bt >> 2;
      end
      return res;
   endfunction

   function automatic longint quadrant(longint a, longint b);
      longint t;
      t = (a >= 2 * b) ? 1 : 0;
      a = a - t * 2 * b;
      return 2 * t + ((a >= b) ? 1 : 0);
   endfunction

   function automatic longint face_coords_to_nest(longint f, longint ring, longint nr,
                                                  longint phi, longint shift, int k);
      longint ns, fm, rr, p, ci, cj;
      ns = longint'(1) << k;
      fm = f & 15;
      rr = ((2 + (fm >> 2)) << k) - ring - 1;
      p = 2 * phi - FACE_COL[fm] * nr - shift - 1;
      if (p >= 2 * ns) p = p - 8 * ns;
      ci = ((rr + p) >>> 1) & (ns - 1);
      cj = ((rr - p) >>> 1) & (ns - 1);
      return (fm << (2 * k)) + spread_coord(ci) + (spread_coord(cj) << 1);
   endfunction

   function automatic longint ring_to_nest_idx(longint r, int k);
      longint ns, npix, ncap, nr, phi, f, ip, tmp, ring, ifm, ifp;
      ns = longint'(1) << k;
      npix = 12 * ns * ns;
      ncap = 2 * ns * (ns - 1);
      if (r < ncap) begin
         nr = (1 + root_floor(2 * r + 1)) >> 1;
         phi = 1 + r - 2 * nr * (nr - 1);
         f = quadrant(phi - 1, nr);
         return face_coords_to_nest(f, nr, nr, phi, 0, k);
      end
      if (npix - ncap <= r) begin
         nr = (1 + root_floor(2 * npix - 2 * r - 1)) >> 1;
         phi = 1 + r + 2 * nr * (nr - 1) + 4 * nr - npix;
         f = quadrant(phi - 1, nr) + 8;
         return face_coords_to_nest(f, 4 * ns - nr, nr, phi, 0, k);
      end
      ip = r - ncap;
      tmp = ip >> (k + 2);
      phi = ip - tmp * 4 * ns + 1;
      ring = tmp + ns;
      ifm = 1 + ((phi - 1 - ((1 + tmp) >>> 1)) >>> k);
      ifp = 1 + ((phi - 1 - ((1 - tmp + 2 * ns) >>> 1)) >>> k);
      f = (ifp == ifm) ? (ifp | 4) : ((ifp < ifm) ? ifp : (ifm + 8));
      return face_coords_to_nest(f, ring, ns, phi, (ring + ns) & 1, k);
   endfunction

   function automatic longint ring_pos(longint f, longint ci, longint cj, longint nr,
                                       longint shift, longint ns);
      longint r;
      r = (FACE_COL[f & 15] * nr + ci - cj + 1 + shift) / 2 - 1;
      if (r < 0) r = r + 4 * ns;
      else if (r >= 4 * ns) r = r - 4 * ns;
      return r;
   endfunction

   function automatic longint nest_to_ring_idx(longint n, int k);
      longint ns, npix, ncap, lo, f, ci, cj, ring, m;
      ns = longint'(1) << k;
      npix = 12 * ns * ns;
      ncap = 2 * ns * (ns - 1);
      lo = n & ((longint'(1) << (2 * k)) - 1);
      f = (n >> (2 * k)) & 15;
      ci = gather_coord(lo);
      cj = gather_coord(lo >> 1);
      ring = ((f >> 2) + 2) * ns - ci - cj - 1;
      if (ring < ns) return 2 * ring * (ring - 1) + ring_pos(f, ci, cj, ring, 0, ns);
      if (ring <= 3 * ns)
         return ncap + (ring - ns) * 4 * ns + ring_pos(f, ci, cj, ns, (ring - ns) & 1, ns);
      m = 4 * ns - ring;
      return npix - 2 * m * (m + 1) + ring_pos(f, ci, cj, m, 0, ns);
   endfunction

   class convert_scoreboard;
      rsp_type pending[$];
      logic [ORDER_W-1:0] order_reg;
      int errors;

      function new();
         order_reg = '0;
         errors = 0;
      endfunction

      function void note_request(req_type rq);
         rsp_type e;
         int k;
         longint npix;
         k = (order_reg > MAX_ORDER) ? MAX_ORDER : order_reg;
         npix = longint'(12) << (2 * k);
         if (longint'(rq.pixel_index) >= npix) begin
            e.converted_index = '0;
            e.index_error = 1'b1;
         end else begin
            if (rq.action == ACT_RING2NEST)
               e.converted_index = PIX_W'(ring_to_nest_idx(longint'(rq.pixel_index), k));
            else
               e.converted_index = PIX_W'(nest_to_ring_idx(longint'(rq.pixel_index), k));
            e.index_error = 1'b0;
         end
         pending.push_back(e);
      endfunction

      function void check_result(rsp_type got);
         rsp_type e;
         if (pending.size() == 0) begin
            $error("unexpected result beat %h", got);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (got.converted_index !== e.converted_index) begin
            $error("converted_index expected %0d actual %0d", e.converted_index,
                   got.converted_index);
            errors++;
         end
         if (got.index_error !== e.index_error) begin
            $error("index_error expected %0d actual %0d", e.index_error, got.index_error);
            errors++;
         end
      endfunction
   endclass

   logic clock, reset;
   logic req_valid, req_ready, rsp_valid, rsp_ready;
   req_type req_data;
   rsp_type rsp_data;
   logic csr_psel, csr_penable, csr_pwrite, csr_pready;
   logic [CSR_AW-1:0] csr_paddr;
   logic [31:0] csr_pwdata, csr_prdata;
   bit quiet_tail;
   convert_scoreboard sb;

   healpix_ring_nest_convert_top dut (.*);

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("healpix_ring_nest_convert_top_tb: FAIL");
      $finish;
   end

   always @(posedge clock)
      if (!reset && rsp_valid && rsp_ready) sb.check_result(rsp_data);

   // Receiver stalls in random bursts until the last phase.
   initial begin
      rsp_ready = 1'b0;
      @(posedge clock);
      forever begin
         if (!quiet_tail && $urandom_range(0, 2) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 30)) @(posedge clock);
      end
   end

   task automatic write_order(logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= CSR_ADDR_ORDER;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      sb.order_reg = value[ORDER_W-1:0];
   endtask

   task automatic wait_drained();
      while (sb.pending.size() != 0) @(posedge clock);
   endtask

   // Presents one beat and returns at the edge where it is taken.
   task automatic send_beat(req_type rq, bit allow_gap);
      if (allow_gap && !quiet_tail && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= rq;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_request(rq);
   endtask

   task automatic run_phase(logic [31:0] order_val, int count, bit pause_once);
      req_type rq;
      int k;
      longint ns, npix, ncap;
      longint edges[12];
      write_order(order_val);
      k = (order_val[3:0] > MAX_ORDER) ? MAX_ORDER : order_val[3:0];
      ns = longint'(1) << k;
      npix = 12 * ns * ns;
      ncap = 2 * ns * (ns - 1);
      edges = '{0, npix - 1, npix, 30'h3fffffff, ncap - 1, ncap, npix - ncap - 1,
                npix - ncap, ns * ns - 1, 4 * ns * ns, 8 * ns * ns - 1, 1};
      foreach (edges[e]) begin
         for (int a = 0; a < 2; a++) begin
            rq.action = a[0];
            rq.pixel_index = PIX_W'((edges[e] < 0) ? 0 : edges[e]);
            send_beat(rq, 1'b1);
         end
      end
      for (int n = 0; n < count; n++) begin
         rq.action = 1'($urandom_range(0, 1));
         if ($urandom_range(0, 9) == 0)
            rq.pixel_index = PIX_W'($urandom);
         else
            rq.pixel_index = PIX_W'($urandom_range(0, 32'(npix - 1)));
         send_beat(rq, 1'b1);
         if (pause_once && n == count / 2) begin
            req_valid <= 1'b0;
            wait_drained();
         end
      end
      req_valid <= 1'b0;
      wait_drained();
      repeat (20) @(posedge clock);
   endtask

   initial begin
      sb = new();
      quiet_tail = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      run_phase(0, 60, 1'b0);
      run_phase(13, 400, 1'b1);
      run_phase(15, 200, 1'b0);
      run_phase(1, 150, 1'b0);
      run_phase(2, 150, 1'b0);
      run_phase(5, 250, 1'b0);
      run_phase($urandom_range(0, 15), 250, 1'b0);
      quiet_tail = 1;
      run_phase(9, 250, 1'b0);
      if (sb.errors == 0)
         $display("healpix_ring_nest_convert_top_tb: PASS");
      else
         $display("healpix_ring_nest_convert_top_tb: FAIL");
      $finish;
   end

endmodule
